### rtl/nmea_sentence_deframer_checksum_defines.svh
// assertion macros used by the deframer checker
// depends on nothing; taken in by `include where assertions are written
`ifndef NMEA_SENTENCE_DEFRAMER_CHECKSUM_DEFINES_SVH
`define NMEA_SENTENCE_DEFRAMER_CHECKSUM_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define NSDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, disabled while reset is held
`define NSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### rtl/nsdc_pkg.sv
// shared types, constants and a helper function of the nmea sentence deframer
// depends on nothing
package nsdc_pkg;

    // sizing
    localparam int MAX_SENTENCE    = 255;
    localparam int OFFSET_BITS     = 32;
    localparam int NAME_CHARS      = 5;
    localparam int NAME_BITS       = 8 * NAME_CHARS;
    localparam int NAME_COUNT_BITS = $clog2(NAME_CHARS + 1);
    localparam int LEN_BITS        = 8;
    localparam int START_BITS      = 32;
    localparam int CFG_WIDTH       = 40;
    localparam int CFG_INDEX_BITS  = 1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_NAME  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_NAME = 1'd1;

    // register reset values: "GPRMC" and "GPGGA"
    localparam logic [CFG_WIDTH-1:0] FIRST_NAME_RESET  = 40'h4750524D43;
    localparam logic [CFG_WIDTH-1:0] SECOND_NAME_RESET = 40'h4750474741;

    // characters with a meaning in the stream
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_A_LESS_TEN = 8'h37;

    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_SENTENCE);

    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_OTHER  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    // one finished sentence
    typedef struct packed {
        kind_t                  kind;
        status_t                status;
        logic [START_BITS-1:0]  start;
        logic [LEN_BITS-1:0]    length;
    } result_t;

    // uppercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (CHAR_ZERO + wide) : (CHAR_A_LESS_TEN + wide);
    endfunction

endpackage

### rtl/nmea_sentence_deframer_checksum.sv
// nmea 0183 sentence deframer with checksum check, top level
// a result is registered into the output register or skid entry as its last checksum item is taken
// throughput: one item per cycle while s_ready is high; the state update is combinational xor, compare and
// count logic, and a two-entry output buffer keeps input flowing while a result waits
// reset: synchronous active-low aresetn clears all state but the output and skid data, names go to GPRMC and GPGGA
// depends on nsdc_pkg and nsdc_tracker
module nmea_sentence_deframer_checksum (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [nsdc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [nsdc_pkg::CFG_WIDTH-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_char_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_sentence_kind,
    output logic [1:0]                           m_check_status,
    output logic [31:0]                          m_start_offset,
    output logic [7:0]                           m_sentence_length
);

    logic [nsdc_pkg::CFG_WIDTH-1:0] first_name_reg;
    logic [nsdc_pkg::CFG_WIDTH-1:0] second_name_reg;

    logic              res_valid;
    nsdc_pkg::result_t res;

    nsdc_pkg::result_t out_reg;
    nsdc_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_name_reg  <= nsdc_pkg::FIRST_NAME_RESET;
            second_name_reg <= nsdc_pkg::SECOND_NAME_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                nsdc_pkg::REG_FIRST_NAME:  first_name_reg  <= cfg_wr_data;
                nsdc_pkg::REG_SECOND_NAME: second_name_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // input side is held only when both buffer entries are occupied
    assign s_ready = !skid_valid_reg;

    nsdc_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .char_accept (s_valid && s_ready),
        .char_in     (s_char_in),
        .first_name  (first_name_reg),
        .second_name (second_name_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // output register with skid entry
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_valid;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (res_valid) begin
                    skid_reg <= res;
                end
            end else if (res_valid) begin
                out_reg <= res;
            end
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_sentence_kind   = out_reg.kind;
    assign m_check_status    = out_reg.status;
    assign m_start_offset    = out_reg.start;
    assign m_sentence_length = out_reg.length;

endmodule

### rtl/nsdc_tracker.sv
// sentence state tracking: checksum, name capture, offsets and length per item
// depends on nsdc_pkg; produces the result of a sentence as its last item is taken
module nsdc_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           char_accept,
    input  logic [7:0]                     char_in,
    input  logic [nsdc_pkg::CFG_WIDTH-1:0] first_name,
    input  logic [nsdc_pkg::CFG_WIDTH-1:0] second_name,
    output logic                           res_valid,
    output nsdc_pkg::result_t              res
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HEX1 = 4'b0100,
        PH_HEX2 = 4'b1000
    } phase_t;

    phase_t                                  phase_reg, phase_next;
    logic [7:0]                              xor_reg, xor_next;
    logic [nsdc_pkg::NAME_BITS-1:0]          name_reg, name_next;
    logic [nsdc_pkg::NAME_COUNT_BITS-1:0]    name_cnt_reg, name_cnt_next;
    logic                                    name_closed_reg, name_closed_next;
    logic                                    name_long_reg, name_long_next;
    logic [nsdc_pkg::OFFSET_BITS-1:0]        pos_reg, pos_next;
    logic [nsdc_pkg::OFFSET_BITS-1:0]        start_reg, start_next;
    logic [nsdc_pkg::LEN_BITS-1:0]           len_reg, len_next;
    logic                                    len_over_reg, len_over_next;
    logic [7:0]                              hex1_reg, hex1_next;

    // saturating length after counting this item
    logic                          at_max;
    logic [nsdc_pkg::LEN_BITS-1:0] len_inc;
    logic                          over_inc;
    logic                          exact;
    logic                          sum_ok;

    assign at_max   = (len_reg >= nsdc_pkg::LEN_MAX);
    assign len_inc  = at_max ? nsdc_pkg::LEN_MAX : (len_reg + nsdc_pkg::LEN_BITS'(1));
    assign over_inc = len_over_reg | at_max;

    // name match and checksum compare for the closing item
    assign exact  = (name_cnt_reg == nsdc_pkg::NAME_COUNT_BITS'(nsdc_pkg::NAME_CHARS))
                    && !name_long_reg;
    assign sum_ok = (hex1_reg == nsdc_pkg::hex_upper(xor_reg[7:4]))
                    && (char_in == nsdc_pkg::hex_upper(xor_reg[3:0]));

    always_comb begin
        res.kind = nsdc_pkg::KIND_OTHER;
        if (exact && (name_reg == first_name[nsdc_pkg::NAME_BITS-1:0])) begin
            res.kind = nsdc_pkg::KIND_FIRST;
        end else if (exact && (name_reg == second_name[nsdc_pkg::NAME_BITS-1:0])) begin
            res.kind = nsdc_pkg::KIND_SECOND;
        end
        if (over_inc) begin
            res.status = nsdc_pkg::STATUS_TOO_LONG;
        end else if (sum_ok) begin
            res.status = nsdc_pkg::STATUS_OK;
        end else begin
            res.status = nsdc_pkg::STATUS_MISMATCH;
        end
        res.start  = nsdc_pkg::START_BITS'(start_reg);
        res.length = len_inc;
    end

    // next state for the accepted item
    always_comb begin
        phase_next       = phase_reg;
        xor_next         = xor_reg;
        name_next        = name_reg;
        name_cnt_next    = name_cnt_reg;
        name_closed_next = name_closed_reg;
        name_long_next   = name_long_reg;
        pos_next         = pos_reg;
        start_next       = start_reg;
        len_next         = len_reg;
        len_over_next    = len_over_reg;
        hex1_next        = hex1_reg;
        res_valid        = 1'b0;

        if (char_accept) begin
            if (char_in == nsdc_pkg::CHAR_NUL) begin
                // zero byte drops the sentence and restarts the offset count
                phase_next = PH_IDLE;
                pos_next   = '0;
            end else begin
                if (char_in == nsdc_pkg::CHAR_DOLLAR) begin
                    phase_next       = PH_BODY;
                    xor_next         = '0;
                    name_next        = '0;
                    name_cnt_next    = '0;
                    name_closed_next = 1'b0;
                    name_long_next   = 1'b0;
                    start_next       = pos_reg + nsdc_pkg::OFFSET_BITS'(1);
                    len_next         = '0;
                    len_over_next    = 1'b0;
                    hex1_next        = '0;
                end else begin
                    case (phase_reg)
                        PH_BODY: begin
                            len_next      = len_inc;
                            len_over_next = over_inc;
                            if (char_in == nsdc_pkg::CHAR_STAR) begin
                                name_closed_next = 1'b1;
                                phase_next       = PH_HEX1;
                            end else begin
                                xor_next = xor_reg ^ char_in;
                                if (!name_closed_reg) begin
                                    if ((char_in == nsdc_pkg::CHAR_COMMA) ||
                                        (char_in == nsdc_pkg::CHAR_CR)) begin
                                        name_closed_next = 1'b1;
                                    end else if (name_cnt_reg <
                                        nsdc_pkg::NAME_COUNT_BITS'(nsdc_pkg::NAME_CHARS)) begin
                                        name_next = (name_reg << 8)
                                                    | nsdc_pkg::NAME_BITS'(char_in);
                                        name_cnt_next = name_cnt_reg
                                                        + nsdc_pkg::NAME_COUNT_BITS'(1);
                                    end else begin
                                        name_long_next = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_HEX1: begin
                            len_next      = len_inc;
                            len_over_next = over_inc;
                            hex1_next     = char_in;
                            phase_next    = PH_HEX2;
                        end
                        PH_HEX2: begin
                            len_next      = len_inc;
                            len_over_next = over_inc;
                            res_valid     = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                        default: begin
                            // idle: characters outside a sentence are dropped
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                pos_next = pos_reg + nsdc_pkg::OFFSET_BITS'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            xor_reg         <= '0;
            name_reg        <= '0;
            name_cnt_reg    <= '0;
            name_closed_reg <= 1'b0;
            name_long_reg   <= 1'b0;
            pos_reg         <= '0;
            start_reg       <= '0;
            len_reg         <= '0;
            len_over_reg    <= 1'b0;
            hex1_reg        <= '0;
        end else begin
            phase_reg       <= phase_next;
            xor_reg         <= xor_next;
            name_reg        <= name_next;
            name_cnt_reg    <= name_cnt_next;
            name_closed_reg <= name_closed_next;
            name_long_reg   <= name_long_next;
            pos_reg         <= pos_next;
            start_reg       <= start_next;
            len_reg         <= len_next;
            len_over_reg    <= len_over_next;
            hex1_reg        <= hex1_next;
        end
    end

endmodule

### rtl/nsdc_checker.sv
// port-level checks of the nmea sentence deframer, bound to the top level
// depends on nsdc_pkg and nmea_sentence_deframer_checksum_defines.svh
`include "nmea_sentence_deframer_checksum_defines.svh"

module nsdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_sentence_kind,
    input logic [1:0]  m_check_status,
    input logic [31:0] m_start_offset,
    input logic [7:0]  m_sentence_length
);

    logic        m_stall;
    logic [43:0] m_payload;
    logic        codes_ok;
    logic        too_long;
    logic        length_full;

    // views of the result channel used below
    assign m_stall     = m_valid && !m_ready;
    assign m_payload   = {m_sentence_kind, m_check_status, m_start_offset, m_sentence_length};
    assign codes_ok    = (m_sentence_kind != 2'd3) && (m_check_status != 2'd3);
    assign too_long    = m_valid && (m_check_status == nsdc_pkg::STATUS_TOO_LONG);
    assign length_full = (m_sentence_length == nsdc_pkg::LEN_MAX);

    // a stalled result holds
    `NSDC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_stall, m_valid && $stable(m_payload))

    // every sentence has at least the star and two checksum characters
    `NSDC_ASSERT_IMPLY(a_min_length, aclk, aresetn, m_valid, m_sentence_length >= 8'd3)

    // kind and status codes stay within their defined values
    `NSDC_ASSERT_IMPLY(a_codes_defined, aclk, aresetn, m_valid, codes_ok)

    // too long always comes with a saturated length
    `NSDC_ASSERT_IMPLY(a_overlong_len, aclk, aresetn, too_long, length_full)

    // input is held off only while results are waiting
    `NSDC_ASSERT_IMPLY(a_stall_has_result, aclk, aresetn, !s_ready, m_valid)

endmodule

bind nmea_sentence_deframer_checksum nsdc_checker u_nsdc_checker (.*);

### bench/tb_nmea_sentence_deframer_checksum.sv
// self-checking bench for the nmea sentence deframer: directed items, then random sentences
// predicts each sentence result, or takes a typed one, and checks the result channel field by field
// depends on nsdc_pkg and nmea_sentence_deframer_checksum
`timescale 1ns / 1ps

module tb_nmea_sentence_deframer_checksum;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    localparam nsdc_pkg::result_t NONE_EXPECTED =
        '{nsdc_pkg::KIND_FIRST, nsdc_pkg::STATUS_OK, 32'd0, 8'd0};

    typedef enum logic [3:0] {
        FR_OUTSIDE = 4'b0001,
        FR_BODY    = 4'b0010,
        FR_SUM_HI  = 4'b0100,
        FR_SUM_LO  = 4'b1000
    } frame_phase_t;

    // one directed item, with its typed-in sentence result where it has one
    typedef struct {
        logic [7:0]        ch;
        bit                typed;
        nsdc_pkg::result_t want;
    } stim_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [nsdc_pkg::CFG_INDEX_BITS-1:0] cfg_index = nsdc_pkg::REG_FIRST_NAME;
    logic [nsdc_pkg::CFG_WIDTH-1:0]      cfg_wr_data = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [7:0]                          s_char_in = 8'h00;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [1:0]                          m_sentence_kind;
    logic [1:0]                          m_check_status;
    logic [31:0]                         m_start_offset;
    logic [7:0]                          m_sentence_length;

    // typed expectation travels with the item it belongs to
    bit                row_typed = 1'b0;
    nsdc_pkg::result_t row_result = NONE_EXPECTED;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_sent = 0;
    int sentence_serial = 0;
    int error_count = 0;
    int cycle_count = 0;

    nsdc_pkg::result_t pending_sentences[$];
    logic [7:0]        char_burst[$];

    // predictor copy of the registers and of the framing state
    logic [39:0]  first_name_cfg = nsdc_pkg::FIRST_NAME_RESET;
    logic [39:0]  second_name_cfg = nsdc_pkg::SECOND_NAME_RESET;
    frame_phase_t frame_ph = FR_OUTSIDE;
    logic [7:0]   xor_acc = 8'h00;
    logic [39:0]  name_sr = '0;
    int           name_cnt = 0;
    bit           name_done = 1'b0;
    bit           name_long = 1'b0;
    logic [31:0]  char_pos = '0;
    logic [31:0]  start_pos = '0;
    logic [7:0]   len_cnt = 8'd0;
    bit           len_over = 1'b0;
    logic [7:0]   sum_hi = 8'h00;

    stim_row_t directed_rows [0:25] = '{
        '{nsdc_pkg::CHAR_STAR,   1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_DOLLAR, 1'b0, NONE_EXPECTED},
        '{"G",                   1'b0, NONE_EXPECTED},
        '{"P",                   1'b0, NONE_EXPECTED},
        '{"R",                   1'b0, NONE_EXPECTED},
        '{"M",                   1'b0, NONE_EXPECTED},
        '{"C",                   1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_STAR,   1'b0, NONE_EXPECTED},
        '{"4",                   1'b0, NONE_EXPECTED},
        '{"B",                   1'b1,
          '{nsdc_pkg::KIND_FIRST, nsdc_pkg::STATUS_OK, 32'd2, 8'd8}},
        '{nsdc_pkg::CHAR_DOLLAR, 1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_STAR,   1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_DOLLAR, 1'b0, NONE_EXPECTED},
        '{"G",                   1'b0, NONE_EXPECTED},
        '{"P",                   1'b0, NONE_EXPECTED},
        '{"G",                   1'b0, NONE_EXPECTED},
        '{"G",                   1'b0, NONE_EXPECTED},
        '{"A",                   1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_CR,     1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_STAR,   1'b0, NONE_EXPECTED},
        '{"5",                   1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_NUL,    1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_DOLLAR, 1'b0, NONE_EXPECTED},
        '{nsdc_pkg::CHAR_STAR,   1'b0, NONE_EXPECTED},
        '{"0",                   1'b0, NONE_EXPECTED},
        '{"1",                   1'b1,
          '{nsdc_pkg::KIND_OTHER, nsdc_pkg::STATUS_MISMATCH, 32'd1, 8'd3}}
    };

    nmea_sentence_deframer_checksum DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_char_in         (s_char_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sentence_kind   (m_sentence_kind),
        .m_check_status    (m_check_status),
        .m_start_offset    (m_start_offset),
        .m_sentence_length (m_sentence_length)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // uppercase hex digit as transmitted after the star
    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        string digits;
        digits = "0123456789ABCDEF";
        return digits[nib];
    endfunction

    // sentence length count, sticking at the maximum
    function automatic void bump_length();
        if (len_cnt >= nsdc_pkg::MAX_SENTENCE) begin
            len_over = 1'b1;
            len_cnt = nsdc_pkg::LEN_MAX;
        end else begin
            len_cnt = len_cnt + 8'd1;
        end
    endfunction

    // advance the deframer state by one character; returns 1 when a sentence closes
    function automatic bit track_sentence(input logic [7:0] c, output nsdc_pkg::result_t res);
        bit exact;
        res = NONE_EXPECTED;
        track_sentence = 1'b0;
        // zero byte drops everything and restarts the offset count
        if (c == nsdc_pkg::CHAR_NUL) begin
            frame_ph = FR_OUTSIDE;
            char_pos = '0;
            return 1'b0;
        end
        if (c == nsdc_pkg::CHAR_DOLLAR) begin
            frame_ph = FR_BODY;
            xor_acc = 8'h00;
            name_sr = '0;
            name_cnt = 0;
            name_done = 1'b0;
            name_long = 1'b0;
            start_pos = char_pos + 32'd1;
            len_cnt = 8'd0;
            len_over = 1'b0;
            sum_hi = 8'h00;
        end else begin
            case (frame_ph)
                FR_BODY: begin
                    bump_length();
                    if (c == nsdc_pkg::CHAR_STAR) begin
                        name_done = 1'b1;
                        frame_ph = FR_SUM_HI;
                    end else begin
                        xor_acc = xor_acc ^ c;
                        // name runs up to the first comma or cr
                        if (!name_done) begin
                            if (c == nsdc_pkg::CHAR_COMMA || c == nsdc_pkg::CHAR_CR) begin
                                name_done = 1'b1;
                            end else if (name_cnt < nsdc_pkg::NAME_CHARS) begin
                                name_sr = {name_sr[31:0], c};
                                name_cnt++;
                            end else begin
                                name_long = 1'b1;
                            end
                        end
                    end
                end
                FR_SUM_HI: begin
                    bump_length();
                    sum_hi = c;
                    frame_ph = FR_SUM_LO;
                end
                FR_SUM_LO: begin
                    bump_length();
                    exact = (name_cnt == nsdc_pkg::NAME_CHARS) && !name_long;
                    if (exact && name_sr == first_name_cfg) begin
                        res.kind = nsdc_pkg::KIND_FIRST;
                    end else if (exact && name_sr == second_name_cfg) begin
                        res.kind = nsdc_pkg::KIND_SECOND;
                    end else begin
                        res.kind = nsdc_pkg::KIND_OTHER;
                    end
                    if (len_over) begin
                        res.status = nsdc_pkg::STATUS_TOO_LONG;
                    end else if (sum_hi == ascii_hex(xor_acc[7:4]) &&
                                 c == ascii_hex(xor_acc[3:0])) begin
                        res.status = nsdc_pkg::STATUS_OK;
                    end else begin
                        res.status = nsdc_pkg::STATUS_MISMATCH;
                    end
                    res.start = start_pos;
                    res.length = len_cnt;
                    track_sentence = 1'b1;
                    frame_ph = FR_OUTSIDE;
                end
                default: ;
            endcase
        end
        char_pos = char_pos + 32'd1;
    endfunction

    function automatic logic [39:0] random_name();
        logic [39:0] name;
        for (int i = 0; i < nsdc_pkg::NAME_CHARS; i++) begin
            name = {name[31:0], 8'h41 + 8'($urandom_range(25))};
        end
        return name;
    endfunction

    // result checking, then prediction for the item taken at this edge
    always @(posedge aclk) begin : watch
        nsdc_pkg::result_t pred;
        nsdc_pkg::result_t want;
        bit                made;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_sentences.size() == 0) begin
                    $error("unexpected result: kind %0d status %0d start %0d len %0d",
                           m_sentence_kind, m_check_status, m_start_offset, m_sentence_length);
                    error_count++;
                end else begin
                    want = pending_sentences.pop_front();
                    if (m_sentence_kind !== want.kind) begin
                        $error("sentence_kind expected %0d, got %0d", want.kind, m_sentence_kind);
                        error_count++;
                    end
                    if (m_check_status !== want.status) begin
                        $error("check_status expected %0d, got %0d", want.status, m_check_status);
                        error_count++;
                    end
                    if (m_start_offset !== want.start) begin
                        $error("start_offset expected %0d, got %0d", want.start, m_start_offset);
                        error_count++;
                    end
                    if (m_sentence_length !== want.length) begin
                        $error("sentence_length expected %0d, got %0d",
                               want.length, m_sentence_length);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                made = track_sentence(s_char_in, pred);
                if (row_typed) begin
                    pending_sentences.push_back(row_result);
                end else if (made) begin
                    pending_sentences.push_back(pred);
                end
            end
        end
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one item and wait for it to be taken
    task automatic offer_char(input logic [7:0] c, input bit typed,
                              input nsdc_pkg::result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_in <= c;
        row_typed <= typed;
        row_result <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // stop sending until every sentence result is in, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        row_typed <= 1'b0;
        @(posedge aclk);
        while (pending_sentences.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // both name registers, back to back
    task automatic write_names(input logic [39:0] first_val, input logic [39:0] second_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= nsdc_pkg::REG_FIRST_NAME;
        cfg_wr_data <= first_val;
        @(posedge aclk);
        cfg_index <= nsdc_pkg::REG_SECOND_NAME;
        cfg_wr_data <= second_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        first_name_cfg = first_val;
        second_name_cfg = second_val;
    endtask

    // random sentences, mostly well formed, some noise and broken ones
    task automatic run_phase(input int idle_tx, input int idle_rx, input int count,
                             input bit hold_rx, input bit pause_mid);
        int          stop_at;
        int          mid;
        bit          paused;
        int          style;
        int          name_len;
        int          body_len;
        int          ending;
        int          keep;
        logic [39:0] pick;
        logic [7:0]  b;
        logic [7:0]  sum;
        send_idle_pct = idle_tx;
        recv_idle_pct = idle_rx;
        if (hold_rx) hold_requests++;
        stop_at = items_sent + count;
        mid = items_sent + count / 2;
        paused = 1'b0;
        while (items_sent < stop_at) begin
            if (pause_mid && !paused && items_sent >= mid) begin
                drain();
                paused = 1'b1;
            end
            char_burst.delete();
            // occasional noise ahead of the sentence
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 4)) char_burst.push_back(8'($urandom_range(255)));
            end
            char_burst.push_back(nsdc_pkg::CHAR_DOLLAR);
            sum = 8'h00;
            // name: a configured one mostly, else random, short or overlong
            style = $urandom_range(9);
            if (style < 4) pick = first_name_cfg;
            else if (style < 7) pick = second_name_cfg;
            else pick = random_name();
            for (int i = 0; i < nsdc_pkg::NAME_CHARS; i++) begin
                b = pick[39 - 8 * i -: 8];
                if (b == nsdc_pkg::CHAR_NUL || b == nsdc_pkg::CHAR_DOLLAR ||
                    b == nsdc_pkg::CHAR_STAR || b == nsdc_pkg::CHAR_COMMA ||
                    b == nsdc_pkg::CHAR_CR) begin
                    pick = random_name();
                end
            end
            name_len = (style >= 8) ? $urandom_range(0, 7) : nsdc_pkg::NAME_CHARS;
            for (int i = 0; i < name_len; i++) begin
                b = (i < nsdc_pkg::NAME_CHARS) ? pick[39 - 8 * i -: 8]
                                               : 8'h41 + 8'($urandom_range(25));
                char_burst.push_back(b);
                sum = sum ^ b;
            end
            // name end and fields
            ending = $urandom_range(2);
            if (ending != 2) begin
                b = (ending == 0) ? nsdc_pkg::CHAR_COMMA : nsdc_pkg::CHAR_CR;
                char_burst.push_back(b);
                sum = sum ^ b;
                body_len = (sentence_serial % 37 == 5) ? $urandom_range(244, 250)
                                                       : $urandom_range(0, 12);
                repeat (body_len) begin
                    do b = 8'($urandom_range(1, 255));
                    while (b == nsdc_pkg::CHAR_DOLLAR || b == nsdc_pkg::CHAR_STAR);
                    char_burst.push_back(b);
                    sum = sum ^ b;
                end
            end
            char_burst.push_back(nsdc_pkg::CHAR_STAR);
            // checksum characters, right most of the time
            if ($urandom_range(4) != 0) begin
                char_burst.push_back(ascii_hex(sum[7:4]));
                char_burst.push_back(ascii_hex(sum[3:0]));
            end else begin
                repeat (2) begin
                    do b = 8'($urandom_range(255));
                    while (b == nsdc_pkg::CHAR_DOLLAR || b == nsdc_pkg::CHAR_NUL);
                    char_burst.push_back(b);
                end
            end
            // broken sentence: cut short, sometimes closed by a zero byte
            if ($urandom_range(11) == 0) begin
                keep = $urandom_range(1, char_burst.size() - 1);
                while (char_burst.size() > keep) void'(char_burst.pop_back());
                if ($urandom_range(1) == 0) char_burst.push_back(nsdc_pkg::CHAR_NUL);
            end
            foreach (char_burst[i]) offer_char(char_burst[i], 1'b0, NONE_EXPECTED);
            sentence_serial++;
        end
        drain();
    endtask

    // reset, directed items, then the random phases
    initial begin
        logic [39:0] shared;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 11;
        recv_idle_pct = 84;
        foreach (directed_rows[i]) begin
            offer_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
        end
        drain();
        run_phase(11, 84, 340, 1'b0, 1'b1);
        write_names('1, '0);
        run_phase(84, 11, 340, 1'b0, 1'b0);
        // same name in both registers: the first one wins
        shared = random_name();
        write_names(shared, shared);
        run_phase(0, 0, 370, 1'b1, 1'b0);
        write_names(random_name(), random_name());
        run_phase(0, 0, 370, 1'b0, 1'b0);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
